[hw/rtl/sfs_pkg.sv]
// Shared types and constants for the stream failover switch.
`default_nettype none
package sfs_pkg;
  localparam logic [2:0] ACT_CONFIG = 3'd0;
  localparam logic [2:0] ACT_RATE   = 3'd1;
  localparam logic [2:0] ACT_REMOTE = 3'd2;
  localparam logic [2:0] ACT_QUERY  = 3'd3;
  localparam logic [2:0] ACT_POLL   = 3'd4;

  localparam logic [2:0] MODE_OFF         = 3'd0;
  localparam logic [2:0] MODE_BACKUP      = 3'd2;
  localparam logic [2:0] MODE_AUTO_REPEAT = 3'd3;
  localparam logic [2:0] MODE_AUTO_ONCE   = 3'd4;
  localparam logic [2:0] MODE_REMOTE      = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch request, read entry
    logic exec;     // apply update / start scan
    logic scan;     // advance scan index
    logic finish;   // present result
  } sfs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } sfs_sts_t;
endpackage
`default_nettype wire

[hw/rtl/stream_failover_switch.sv]
// Top level of the stream failover switch.
//
// channel | ports                       | handshake
// input   | in_*                        | start & !busy
// result  | out_*                       | out_strobe, one cycle
// config  | cfg_we, cfg_data            | cfg_we
//
// Each request runs the backup-use scan over the selected table:
// the scan reads one table entry a cycle.
// Synchronous active-low reset clears tables, flag and max_tolerance (to 1).
// The receiver cannot stall; busy holds off new requests during work.
`default_nettype none
module stream_failover_switch #(
  parameter int IN_CHANNELS  = 16,
  parameter int OUT_CHANNELS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic        in_is_input,
  input  wire logic [7:0]  in_channel,
  input  wire logic [31:0] in_bitrate,
  input  wire logic [31:0] in_low_limit,
  input  wire logic [31:0] in_high_limit,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_backup_channel,
  input  wire logic        in_select_main,
  output logic             out_strobe,
  output logic             out_index_ok,
  output logic [7:0]       out_served_channel,
  output logic             out_on_backup,
  output logic             out_used_as_backup,
  output logic             out_changed,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data
);
  import sfs_pkg::*;

  sfs_cmd_t cmd;
  sfs_sts_t sts;
  logic [7:0] max_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) max_tol_r <= 8'd1;
    else if (cfg_we) max_tol_r <= cfg_data;
  end

  sfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  sfs_dp #(.IN_CHANNELS(IN_CHANNELS), .OUT_CHANNELS(OUT_CHANNELS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .max_tol(max_tol_r),
    .in_action(in_action), .in_is_input(in_is_input), .in_channel(in_channel),
    .in_bitrate(in_bitrate), .in_low_limit(in_low_limit),
    .in_high_limit(in_high_limit), .in_mode(in_mode),
    .in_backup_channel(in_backup_channel), .in_select_main(in_select_main),
    .res_valid(out_strobe), .res_index_ok(out_index_ok),
    .res_served(out_served_channel), .res_on_backup(out_on_backup),
    .res_used(out_used_as_backup), .res_changed(out_changed)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe held two cycles");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while still busy");
  a_fields_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_changed) |-> (!out_on_backup && !out_used_as_backup))
    else $error("poll result carries query fields");
endmodule
`default_nettype wire

[hw/rtl/sfs_ctrl.sv]
// Sequencer for the stream failover switch.
`default_nettype none
module sfs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  sfs_pkg::sfs_sts_t    sts,
  output sfs_pkg::sfs_cmd_t    cmd
);
  import sfs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.exec = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

[hw/rtl/sfs_dp.sv]
// Channel tables, update logic and backup-use scan.
`default_nettype none
module sfs_dp #(
  parameter int IN_CHANNELS  = 16,
  parameter int OUT_CHANNELS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  sfs_pkg::sfs_cmd_t  cmd,
  output sfs_pkg::sfs_sts_t  sts,
  input  wire logic [7:0]    max_tol,
  input  wire logic [2:0]    in_action,
  input  wire logic          in_is_input,
  input  wire logic [7:0]    in_channel,
  input  wire logic [31:0]   in_bitrate,
  input  wire logic [31:0]   in_low_limit,
  input  wire logic [31:0]   in_high_limit,
  input  wire logic [2:0]    in_mode,
  input  wire logic [7:0]    in_backup_channel,
  input  wire logic          in_select_main,
  output logic               res_valid,
  output logic               res_index_ok,
  output logic [7:0]         res_served,
  output logic               res_on_backup,
  output logic               res_used,
  output logic               res_changed
);
  import sfs_pkg::*;

  localparam int NMAX = (IN_CHANNELS > OUT_CHANNELS) ? IN_CHANNELS : OUT_CHANNELS;
  localparam int IW = (NMAX > 1) ? $clog2(NMAX) : 1;
  localparam int IIW = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int OIW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

  logic [31:0] in_lo_r [IN_CHANNELS];
  logic [31:0] in_hi_r [IN_CHANNELS];
  logic [2:0]  in_mode_r [IN_CHANNELS];
  logic [7:0]  in_bk_r [IN_CHANNELS];
  logic [7:0]  in_cnt_r [IN_CHANNELS];
  logic        in_st_r [IN_CHANNELS];
  logic [2:0]  out_mode_r [OUT_CHANNELS];
  logic [7:0]  out_bk_r [OUT_CHANNELS];
  logic        out_st_r [OUT_CHANNELS];
  logic        chg_r;

  // latched request
  logic [2:0]  act_r;
  logic        use_in_r, ok_r, sel_r;
  logic [7:0]  ch_r, bk_r;
  logic [31:0] rate_r, lo_r, hi_r;
  logic [2:0]  mode_r;
  // entry read
  logic [31:0] e_lo_r, e_hi_r;
  logic [2:0]  e_mode_r;
  logic [7:0]  e_bk_r, e_cnt_r;
  logic        e_st_r;
  logic [IW-1:0] idx_r;
  logic        used_r;

  logic use_in, ok;
  always_comb begin
    use_in = in_is_input;
    if (in_action == ACT_RATE) use_in = 1'b1;
    else if (in_action == ACT_REMOTE) use_in = 1'b0;
    ok = use_in ? ({1'b0, in_channel} < 9'(IN_CHANNELS))
                : ({1'b0, in_channel} < 9'(OUT_CHANNELS));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action; use_in_r <= use_in; ok_r <= ok; ch_r <= in_channel;
      rate_r <= in_bitrate; lo_r <= in_low_limit; hi_r <= in_high_limit;
      mode_r <= (in_mode > MODE_REMOTE) ? MODE_OFF : in_mode;
      bk_r <= in_backup_channel; sel_r <= in_select_main;
      e_lo_r <= in_lo_r[in_channel[IIW-1:0]];
      e_hi_r <= in_hi_r[in_channel[IIW-1:0]];
      e_cnt_r <= in_cnt_r[in_channel[IIW-1:0]];
      if (use_in) begin
        e_mode_r <= in_mode_r[in_channel[IIW-1:0]];
        e_bk_r <= in_bk_r[in_channel[IIW-1:0]];
        e_st_r <= in_st_r[in_channel[IIW-1:0]];
      end else begin
        e_mode_r <= out_mode_r[in_channel[OIW-1:0]];
        e_bk_r <= out_bk_r[in_channel[OIW-1:0]];
        e_st_r <= out_st_r[in_channel[OIW-1:0]];
      end
    end
  end

  // bitrate update
  logic        fault;
  logic [7:0]  cnt_nxt;
  logic        st_nxt, rchg;
  always_comb begin
    fault = (rate_r < e_lo_r) || (rate_r > e_hi_r);
    cnt_nxt = e_cnt_r;
    if (fault) begin
      if (e_cnt_r < max_tol) cnt_nxt = e_cnt_r + 8'd1;
    end else if (e_cnt_r != 8'd0) begin
      cnt_nxt = e_cnt_r - 8'd1;
    end
    st_nxt = e_st_r;
    rchg = 1'b0;
    if ((e_mode_r == MODE_AUTO_REPEAT || e_mode_r == MODE_AUTO_ONCE) && !st_nxt
        && cnt_nxt == max_tol) begin
      st_nxt = 1'b1; rchg = 1'b1;
    end
    if (e_mode_r == MODE_AUTO_REPEAT && st_nxt && cnt_nxt == 8'd0) begin
      st_nxt = 1'b0; rchg = 1'b1;
    end
  end

  logic scan_last_w;
  assign scan_last_w = use_in_r ? (32'(idx_r) == 32'(IN_CHANNELS - 1))
                                : (32'(idx_r) == 32'(OUT_CHANNELS - 1));
  assign sts.scan_last = scan_last_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IN_CHANNELS; i++) begin
        in_lo_r[i] <= '0; in_hi_r[i] <= '0; in_mode_r[i] <= MODE_OFF;
        in_bk_r[i] <= '0; in_cnt_r[i] <= '0; in_st_r[i] <= 1'b0;
      end
      for (int i = 0; i < OUT_CHANNELS; i++) begin
        out_mode_r[i] <= MODE_OFF; out_bk_r[i] <= '0; out_st_r[i] <= 1'b0;
      end
      chg_r <= 1'b0;
    end else begin
      if (cmd.exec && ok_r) begin
        case (act_r)
          ACT_CONFIG: begin
            if (use_in_r) begin
              in_lo_r[ch_r[IIW-1:0]] <= lo_r; in_hi_r[ch_r[IIW-1:0]] <= hi_r;
              in_mode_r[ch_r[IIW-1:0]] <= mode_r; in_bk_r[ch_r[IIW-1:0]] <= bk_r;
              in_st_r[ch_r[IIW-1:0]] <= (mode_r == MODE_BACKUP);
              in_cnt_r[ch_r[IIW-1:0]] <= '0;
            end else begin
              out_mode_r[ch_r[OIW-1:0]] <= mode_r; out_bk_r[ch_r[OIW-1:0]] <= bk_r;
              out_st_r[ch_r[OIW-1:0]] <= (mode_r == MODE_BACKUP);
            end
          end
          ACT_RATE: begin
            in_cnt_r[ch_r[IIW-1:0]] <= cnt_nxt;
            in_st_r[ch_r[IIW-1:0]] <= st_nxt;
            if (rchg) chg_r <= 1'b1;
          end
          ACT_REMOTE: begin
            if (e_mode_r == MODE_REMOTE) begin
              out_st_r[ch_r[OIW-1:0]] <= !sel_r;
              if ((!sel_r) != e_st_r) chg_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish && act_r == ACT_POLL) chg_r <= 1'b0;
    end
  end

  // backup-use scan, one entry a cycle
  logic        hit;
  logic [2:0]  s_mode;
  logic [7:0]  s_bk;
  always_comb begin
    if (use_in_r) begin
      s_mode = in_mode_r[idx_r[IIW-1:0]]; s_bk = in_bk_r[idx_r[IIW-1:0]];
    end else begin
      s_mode = out_mode_r[idx_r[OIW-1:0]]; s_bk = out_bk_r[idx_r[OIW-1:0]];
    end
    hit = (8'(idx_r) != ch_r) && (s_mode != MODE_OFF) && (s_bk == ch_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx_r <= '0; used_r <= 1'b0;
    end else if (cmd.scan) begin
      if (hit) used_r <= 1'b1;
      if (!scan_last_w) idx_r <= idx_r + IW'(1);
    end
  end

  logic bk_ok;
  assign bk_ok = use_in_r ? ({1'b0, e_bk_r} < 9'(IN_CHANNELS))
                          : ({1'b0, e_bk_r} < 9'(OUT_CHANNELS));

  always_ff @(posedge clk) begin
    if (!rst_n) res_valid <= 1'b0;
    else res_valid <= cmd.finish;
    if (cmd.finish) begin
      res_index_ok <= ok_r;
      res_served <= '0; res_on_backup <= 1'b0; res_used <= 1'b0; res_changed <= 1'b0;
      if (act_r == ACT_QUERY) begin
        res_served <= (ok_r && e_st_r && bk_ok) ? e_bk_r : ch_r;
        res_on_backup <= ok_r && e_st_r;
        res_used <= ok_r && used_r;
      end
      if (act_r == ACT_POLL) res_changed <= chg_r;
    end
  end
endmodule
`default_nettype wire
